// ----- rtl/mfd_pkg.sv -----
package mfd_pkg;

    // Field widths
    localparam int LenW      = 28;
    localparam int TopicW    = 16;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 32;

    // Register map (word index taken from paddr[2])
    localparam logic REG_MAX_TOPIC = 1'b0;
    localparam logic [TopicW-1:0] MaxTopicReset = 16'd159;

    // Frame type high nibble of a PUBLISH
    localparam logic [3:0] TYPE_PUBLISH = 4'h3;

    // Field kinds
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_TOPIC_LEN = 3'd1;
    localparam logic [2:0] KIND_TOPIC     = 3'd2;
    localparam logic [2:0] KIND_PACKET_ID = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LEN_LONG  = 2'd1;
    localparam logic [1:0] ERR_BAD_TOPIC = 2'd2;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

endpackage

// ----- rtl/mfd_in_if.sv -----
interface mfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ----- rtl/mfd_out_if.sv -----
interface mfd_out_if;
    logic                     valid;
    logic                     ready;
    logic [7:0]               frame_type;
    logic [mfd_pkg::LenW-1:0] remaining_length;
    logic [7:0]               body_byte;
    logic                     has_byte;
    logic [mfd_pkg::LenW-1:0] body_offset;
    logic [2:0]               field_kind;
    logic [1:0]               publish_qos;
    logic                     frame_end;
    logic [1:0]               error_code;

    modport source (
        output valid, output frame_type, output remaining_length, output body_byte,
        output has_byte, output body_offset, output field_kind, output publish_qos,
        output frame_end, output error_code, input ready
    );
    modport sink (
        input valid, input frame_type, input remaining_length, input body_byte,
        input has_byte, input body_offset, input field_kind, input publish_qos,
        input frame_end, input error_code, output ready
    );
endinterface

// ----- rtl/mfd_cfg_regs.sv -----
module mfd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfd_pkg::CfgAddrW-1:0]  paddr,
    input  logic [mfd_pkg::CfgDataW-1:0]  pwdata,
    output logic [mfd_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    output logic [mfd_pkg::TopicW-1:0]    o_max_topic_len
);

    logic [mfd_pkg::TopicW-1:0] r_max_topic;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Store the low half of the word on a write to the topic limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_topic <= mfd_pkg::MaxTopicReset;
        end else if (w_wr && (paddr[2] == mfd_pkg::REG_MAX_TOPIC)) begin
            r_max_topic <= pwdata[mfd_pkg::TopicW-1:0];
        end
    end

    // Read back the register, zero elsewhere
    always_comb begin
        if (paddr[2] == mfd_pkg::REG_MAX_TOPIC) begin
            prdata = {{(mfd_pkg::CfgDataW-mfd_pkg::TopicW){1'b0}}, r_max_topic};
        end else begin
            prdata = '0;
        end
    end

    assign o_max_topic_len = r_max_topic;

endmodule

// ----- rtl/mfd_parser.sv -----
module mfd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mfd_pkg::TopicW-1:0] i_max_topic_len,
    mfd_in_if.sink                     s_in,
    mfd_out_if.source                  m_out
);

    localparam int LenW = mfd_pkg::LenW;

    // Frame state
    mfd_pkg::t_phase     r_phase, n_phase;
    logic [7:0]          r_type, n_type;
    logic [LenW-1:0]     r_accum, n_accum;
    logic [1:0]          r_len_cnt, n_len_cnt;
    logic [LenW-1:0]     r_body_cnt, n_body_cnt;
    logic [15:0]         r_topic, n_topic;

    // Result register
    logic                r_out_valid;
    logic [7:0]          r_o_type;
    logic [LenW-1:0]     r_o_len;
    logic [7:0]          r_o_byte;
    logic                r_o_has;
    logic [LenW-1:0]     r_o_off;
    logic [2:0]          r_o_kind;
    logic                r_o_end;
    logic [1:0]          r_o_err;

    // Result of this byte
    logic                w_emit;
    logic [LenW-1:0]     w_len;
    logic                w_has;
    logic [LenW-1:0]     w_off;
    logic [2:0]          w_kind;
    logic                w_end;
    logic [1:0]          w_err;

    logic                w_accept;
    logic [7:0]          w_b;
    logic [LenW-1:0]     w_group;
    logic                w_is_pub;
    logic [17:0]         w_idlen;
    logic [17:0]         w_span_topic;
    logic [17:0]         w_span_id;
    logic [15:0]         w_tl_new;
    logic [17:0]         w_need;
    logic [LenW:0]       w_off_p1;
    logic                w_body_end;

    assign s_in.ready = !r_out_valid || m_out.ready;
    assign w_accept   = s_in.valid && s_in.ready;
    assign w_b        = s_in.stream_byte;

    assign w_is_pub     = (r_type[7:4] == mfd_pkg::TYPE_PUBLISH);
    assign w_idlen      = (r_type[2:1] != 2'd0) ? 18'd2 : 18'd0;
    assign w_span_topic = 18'd2 + {2'b00, r_topic};
    assign w_span_id    = w_span_topic + w_idlen;
    assign w_tl_new     = {r_topic[15:8], w_b};
    assign w_need       = 18'd2 + {2'b00, w_tl_new} + w_idlen;
    assign w_off_p1     = {1'b0, r_body_cnt} + {{LenW{1'b0}}, 1'b1};
    assign w_body_end   = (w_off_p1 >= {1'b0, r_accum});

    // Place the length group by its position
    always_comb begin
        unique case (r_len_cnt)
            2'd0: w_group = {21'd0, w_b[6:0]};
            2'd1: w_group = {14'd0, w_b[6:0], 7'd0};
            2'd2: w_group = {7'd0, w_b[6:0], 14'd0};
            2'd3: w_group = {w_b[6:0], 21'd0};
            default: w_group = '0;
        endcase
    end

    // Decode one byte
    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_accum    = r_accum;
        n_len_cnt  = r_len_cnt;
        n_body_cnt = r_body_cnt;
        n_topic    = r_topic;
        w_emit     = 1'b0;
        w_len      = r_accum;
        w_has      = 1'b0;
        w_off      = '0;
        w_kind     = mfd_pkg::KIND_NONE;
        w_end      = 1'b0;
        w_err      = mfd_pkg::ERR_NONE;
        unique case (r_phase)
            mfd_pkg::PH_TYPE: begin
                n_type     = w_b;
                n_accum    = '0;
                n_len_cnt  = 2'd0;
                n_body_cnt = '0;
                n_topic    = '0;
                n_phase    = mfd_pkg::PH_LEN;
            end
            mfd_pkg::PH_LEN: begin
                n_accum   = r_accum | w_group;
                n_len_cnt = r_len_cnt + 2'd1;
                w_len     = n_accum;
                if (w_b[7]) begin
                    // Continuation on the fourth length byte: flag and resync on the next byte
                    if (r_len_cnt == 2'd3) begin
                        w_emit  = 1'b1;
                        w_end   = 1'b1;
                        w_err   = mfd_pkg::ERR_LEN_LONG;
                        n_phase = mfd_pkg::PH_TYPE;
                    end
                end else if (n_accum == '0) begin
                    // Empty frame: one marker
                    w_emit  = 1'b1;
                    w_end   = 1'b1;
                    w_err   = w_is_pub ? mfd_pkg::ERR_BAD_TOPIC : mfd_pkg::ERR_NONE;
                    n_phase = mfd_pkg::PH_TYPE;
                end else begin
                    n_body_cnt = '0;
                    n_phase    = mfd_pkg::PH_BODY;
                end
            end
            mfd_pkg::PH_BODY: begin
                w_emit = 1'b1;
                w_has  = 1'b1;
                w_off  = r_body_cnt;
                w_end  = w_body_end;
                if (w_is_pub) begin
                    if (r_body_cnt == '0) begin
                        n_topic = {w_b, 8'h00};
                        if (w_body_end) begin
                            w_err = mfd_pkg::ERR_BAD_TOPIC;
                        end
                    end else if (r_body_cnt == {{(LenW-1){1'b0}}, 1'b1}) begin
                        n_topic = w_tl_new;
                        if ((w_tl_new == 16'd0) || (w_tl_new > i_max_topic_len) ||
                            ({{(LenW-18){1'b0}}, w_need} > r_accum)) begin
                            w_err = mfd_pkg::ERR_BAD_TOPIC;
                        end
                    end
                    // Tag by offset within the publish body
                    if (r_body_cnt[LenW-1:1] == '0) begin
                        w_kind = mfd_pkg::KIND_TOPIC_LEN;
                    end else if (r_body_cnt < {{(LenW-18){1'b0}}, w_span_topic}) begin
                        w_kind = mfd_pkg::KIND_TOPIC;
                    end else if (r_body_cnt < {{(LenW-18){1'b0}}, w_span_id}) begin
                        w_kind = mfd_pkg::KIND_PACKET_ID;
                    end else begin
                        w_kind = mfd_pkg::KIND_PAYLOAD;
                    end
                end
                if (w_body_end) begin
                    n_phase = mfd_pkg::PH_TYPE;
                end else begin
                    n_body_cnt = w_off_p1[LenW-1:0];
                end
            end
            default: begin
                n_phase = mfd_pkg::PH_TYPE;
            end
        endcase
    end

    // Advance frame state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mfd_pkg::PH_TYPE;
            r_type     <= '0;
            r_accum    <= '0;
            r_len_cnt  <= '0;
            r_body_cnt <= '0;
            r_topic    <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_accum    <= n_accum;
            r_len_cnt  <= n_len_cnt;
            r_body_cnt <= n_body_cnt;
            r_topic    <= n_topic;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_o_type <= r_type;
            r_o_len  <= w_len;
            r_o_byte <= w_has ? w_b : 8'h00;
            r_o_has  <= w_has;
            r_o_off  <= w_off;
            r_o_kind <= w_kind;
            r_o_end  <= w_end;
            r_o_err  <= w_err;
        end
    end

    assign m_out.valid            = r_out_valid;
    assign m_out.frame_type       = r_o_type;
    assign m_out.remaining_length = r_o_len;
    assign m_out.body_byte        = r_o_byte;
    assign m_out.has_byte         = r_o_has;
    assign m_out.body_offset      = r_o_off;
    assign m_out.field_kind       = r_o_kind;
    assign m_out.publish_qos      = r_o_type[2:1];
    assign m_out.frame_end        = r_o_end;
    assign m_out.error_code       = r_o_err;

endmodule

// ----- rtl/mqtt_frame_deframer_core.sv -----
// MQTT 3.1.1 fixed-header deframer.
// i_in carries the received byte stream, one byte per word. The first byte
// of a frame is its type byte, then 1 to 4 remaining-length bytes; these give
// no result but for a marker word. Each body byte then leaves on o_out with its
// offset, the frame's type and length, a PUBLISH field tag and frame_end on the
// last byte. A zero-length frame gives one marker word with has_byte low.
// Throughput is one byte per cycle while the receiver takes results: the byte
// is decoded in the cycle it is accepted and its result sits in the output register from the next cycle.
// The output register frees the input side: a new byte is taken whenever
// the register is empty or is being read in the same cycle. When the
// receiver stalls with a result pending, i_in.ready drops and the result
// holds.
// The APB port holds max_topic_len at address 0 (reset 159); write it only
// while the stream is idle.
// Synchronous reset returns the parser to waiting for a type byte and
// empties the output register.
module mqtt_frame_deframer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mfd_in_if.sink                        i_in,
    mfd_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfd_pkg::CfgAddrW-1:0]  paddr,
    input  logic [mfd_pkg::CfgDataW-1:0]  pwdata,
    output logic [mfd_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready
);

    logic [mfd_pkg::TopicW-1:0] w_max_topic;

    mfd_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_max_topic_len (w_max_topic)
    );

    mfd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_topic_len (w_max_topic),
        .s_in            (i_in),
        .m_out           (o_out)
    );

    // A marker word always closes its frame
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_byte) |-> o_out.frame_end)
        else $error("marker word without frame_end");

    // Length overrun is reported only on a marker
    a_len_err_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.error_code == mfd_pkg::ERR_LEN_LONG)) |-> !o_out.has_byte)
        else $error("length error on a data word");

    // Field tags appear only in PUBLISH frames
    a_kind_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.field_kind != mfd_pkg::KIND_NONE))
        |-> (o_out.frame_type[7:4] == mfd_pkg::TYPE_PUBLISH))
        else $error("field tag outside a PUBLISH frame");

    // Input is blocked only while a result waits
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a pending result");

endmodule
